// ===== rtl/core/pes_pkg.sv =====
// Shared types and constants for the periodic event splitter.
package pes_pkg;

   localparam int TIME_FIELD_W = 24;
   localparam int TAG_W        = 16;

   localparam logic [TIME_FIELD_W-1:0] PERIOD_RESET = 24'd1000;

   typedef struct packed {
      logic                    is_readout;
      logic                    readout_start;
      logic [TIME_FIELD_W-1:0] duration;
      logic [TAG_W-1:0]        op_tag;
   } req_item_type;

   typedef struct packed {
      logic                    is_flow;
      logic [TIME_FIELD_W-1:0] piece_length;
      logic [TAG_W-1:0]        piece_tag;
      logic                    overflow;
      logic                    last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      EK_WHOLE,
      EK_OVF,
      EK_PIECE,
      EK_FLOW,
      EK_FINAL
   } emit_kind_type;

   typedef struct packed {
      logic          capture;
      logic          div_start;
      logic          div_sel_sum;
      logic          e_from_elapsed;
      logic          e_from_div;
      logic          commit_ro;
      logic          commit_elapsed;
      logic          load_cross;
      logic          step_cross;
      logic          emit;
      emit_kind_type emit_kind;
   } cmd_type;

   typedef struct packed {
      logic dur_zero;
      logic stale;
      logic ro;
      logic too_many;
      logic cross_zero;
      logic last_cross;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/periodic_event_splitter.sv =====
// Top level of the periodic event splitter: controller, datapath and ports.
//
// The block takes one timed sequence operation at a time and tracks the ticks
// elapsed in the current flow period plus a readout-active flag. Outside
// readout an operation leaves as one item and the phase advances modulo the
// period; inside readout it is cut at each period boundary with a zero-length
// flow item after every cut piece, the last piece carrying the remainder and
// marked last. Too many boundary crossings yield one overflow item and leave
// the state alone. A zero-length operation leaves whole with no division;
// any other one has the sum of its duration and the held phase divided by
// the period to count its boundary crossings, and a split one then emits a
// piece and a flow item per crossing and one final piece. A further division
// first reduces the held phase when it is not below a newly written period.
// The block has one shared bit-serial divider, which resolves one quotient
// bit per cycle, and a single result register, which moves one item per
// cycle unless the result side stalls.
// A finished result waits in that register while the next operation is taken
// in. Write flow_period through the csr port only while the block is idle.
module periodic_event_splitter import pes_pkg::*; #(
   parameter int MAX_CROSSINGS = 31,
   parameter int TIME_BITS     = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   // operation input
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_item_type            req_data,
   // result output
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_item_type            rsp_data,
   // flow_period write port
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [TIME_FIELD_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type sts;

   // the period register takes a write on any cycle
   assign csr_ready = 1'b1;

   // sequence each item: divide, commit state, then drain results
   pes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold state, do the period arithmetic and drive the result register
   pes_datapath #(
      .MAX_CROSSINGS (MAX_CROSSINGS),
      .TIME_BITS     (TIME_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/pes_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pes_div import pes_pkg::*; #(
   parameter int TIME_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS:0]   dividend,
   input  logic [TIME_BITS-1:0] divisor,
   output logic                 busy,
   output logic [TIME_BITS:0]   quotient,
   output logic [TIME_BITS-1:0] remainder
);

   localparam int W  = TIME_BITS + 1;
   localparam int NW = $clog2(W + 1);

   logic [W-1:0]         quo_ff, quo_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [NW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [TIME_BITS:0]   trial;
   logic [TIME_BITS:0]   diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[W-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = NW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
         quo_in  = {quo_ff[W-2:0], ge};
         cnt_in  = cnt_ff - NW'(1);
         busy_in = (cnt_ff != NW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not go busy after start");

endmodule

// ===== rtl/core/pes_datapath.sv =====
// Datapath: period and phase state, operation registers, divider, result register.
module pes_datapath import pes_pkg::*; #(
   parameter int MAX_CROSSINGS = 31,
   parameter int TIME_BITS     = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              sts,
   input  req_item_type            req_data,
   input  logic                    csr_we,
   input  logic [TIME_FIELD_W-1:0] csr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_item_type            rsp_data
);

   localparam int W     = TIME_BITS + 1;
   localparam int CW    = $clog2(MAX_CROSSINGS + 1);
   localparam int PAD_W = (TIME_BITS > TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;

   logic [TIME_BITS-1:0] period_ff, period_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic                 ro_state_ff, ro_state_in;
   logic                 ro_ff, ro_in;
   logic [TIME_BITS-1:0] dur_ff, dur_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [TIME_BITS-1:0] e_ff, e_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 first_ff, first_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_data_ff, rsp_data_in;

   logic [PAD_W-1:0]     csr_wide;
   logic [PAD_W-1:0]     dur_wide;
   logic [TIME_BITS-1:0] period_eff;
   logic [W-1:0]         dividend;
   logic                 div_busy;
   logic [W-1:0]         div_quo;
   logic [TIME_BITS-1:0] div_rem;
   logic [TIME_BITS-1:0] len;
   rsp_item_type         result;

   assign csr_wide   = PAD_W'(csr_data);
   assign dur_wide   = PAD_W'(req_data.duration);
   // a zero period counts as one tick
   assign period_eff = (period_ff == '0) ? TIME_BITS'(1) : period_ff;
   assign dividend   = cmd.div_sel_sum ? (W'(dur_ff) + W'(e_ff)) : W'(elapsed_ff);

   pes_div #(.TIME_BITS(TIME_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (period_eff),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      len = '0;
      case (cmd.emit_kind)
         EK_WHOLE: len = dur_ff;
         EK_PIECE: len = first_ff ? (period_eff - e_ff) : period_eff;
         EK_FINAL: len = first_ff ? dur_ff : div_rem;
         default:  len = '0;
      endcase
      result.is_flow      = (cmd.emit_kind == EK_FLOW);
      result.piece_length = TIME_FIELD_W'(len);
      result.piece_tag    = tag_ff;
      result.overflow     = (cmd.emit_kind == EK_OVF);
      result.last         = (cmd.emit_kind == EK_WHOLE) || (cmd.emit_kind == EK_OVF) ||
                            (cmd.emit_kind == EK_FINAL);
   end

   always_comb begin
      period_in    = csr_we ? csr_wide[TIME_BITS-1:0] : period_ff;
      ro_in        = ro_ff;
      dur_in       = dur_ff;
      tag_in       = tag_ff;
      if (cmd.capture) begin
         ro_in  = req_data.is_readout ? req_data.readout_start : ro_state_ff;
         dur_in = dur_wide[TIME_BITS-1:0];
         tag_in = req_data.op_tag;
      end
      e_in = e_ff;
      if (cmd.e_from_elapsed) begin
         e_in = elapsed_ff;
      end else if (cmd.e_from_div) begin
         e_in = div_rem;
      end
      ro_state_in = cmd.commit_ro ? ro_ff : ro_state_ff;
      elapsed_in  = cmd.commit_elapsed ? div_rem : elapsed_ff;
      cnt_in      = cnt_ff;
      first_in    = first_ff;
      if (cmd.load_cross) begin
         cnt_in   = div_quo[CW-1:0];
         first_in = 1'b1;
      end else if (cmd.step_cross) begin
         cnt_in   = cnt_ff - CW'(1);
         first_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= TIME_BITS'(PERIOD_RESET);
         elapsed_ff   <= '0;
         ro_state_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         elapsed_ff   <= elapsed_in;
         ro_state_ff  <= ro_state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ro_ff       <= ro_in;
      dur_ff      <= dur_in;
      tag_ff      <= tag_in;
      e_ff        <= e_in;
      cnt_ff      <= cnt_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.dur_zero   = (dur_ff == '0);
   assign sts.stale      = (elapsed_ff >= period_eff);
   assign sts.ro         = ro_ff;
   assign sts.too_many   = (div_quo > W'(MAX_CROSSINGS));
   assign sts.cross_zero = (div_quo == '0);
   assign sts.last_cross = (cnt_ff == CW'(1));
   assign sts.div_busy   = div_busy;
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_elapsed_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_elapsed |=> elapsed_ff < period_eff)
      else $error("elapsed time left outside the period");

   a_cross_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.load_cross |-> !sts.too_many && !div_busy)
      else $error("crossing count loaded while out of range or dividing");

endmodule

// ===== rtl/core/pes_ctrl.sv =====
// Controller: sequences division, state commit and result emission per item.
module pes_ctrl import pes_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_E,
      ST_LOAD_SUM,
      ST_DIV_S,
      ST_DECIDE,
      ST_PIECE,
      ST_FLOW,
      ST_FINAL
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.dur_zero) begin
               if (sts.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = EK_WHOLE;
                  cmd.commit_ro = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (sts.stale) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_E;
            end else begin
               cmd.e_from_elapsed = 1'b1;
               state_in           = ST_LOAD_SUM;
            end
         end
         ST_DIV_E: begin
            if (!sts.div_busy) begin
               cmd.e_from_div = 1'b1;
               state_in       = ST_LOAD_SUM;
            end
         end
         ST_LOAD_SUM: begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_sum = 1'b1;
            state_in        = ST_DIV_S;
         end
         ST_DIV_S: begin
            if (!sts.div_busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!sts.ro) begin
               if (sts.out_free) begin
                  cmd.emit           = 1'b1;
                  cmd.emit_kind      = EK_WHOLE;
                  cmd.commit_ro      = 1'b1;
                  cmd.commit_elapsed = 1'b1;
                  state_in           = ST_IDLE;
               end
            end else if (sts.too_many) begin
               if (sts.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = EK_OVF;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.commit_ro      = 1'b1;
               cmd.commit_elapsed = 1'b1;
               cmd.load_cross     = 1'b1;
               state_in           = sts.cross_zero ? ST_FINAL : ST_PIECE;
            end
         end
         ST_PIECE: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EK_PIECE;
               state_in      = ST_FLOW;
            end
         end
         ST_FLOW: begin
            if (sts.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_kind  = EK_FLOW;
               cmd.step_cross = 1'b1;
               state_in       = sts.last_cross ? ST_FINAL : ST_PIECE;
            end
         end
         ST_FINAL: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EK_FINAL;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result emitted over a stalled result");

endmodule
